// File: hdl/cmfr_pkg.sv
// shared types, codes and the crc byte update for the modbus frame receiver
`timescale 1ns / 1ps
`default_nettype none

package cmfr_pkg;

  // frame positions are compared at this width whatever the frame length
  localparam int POS_W       = 7;
  localparam int POS_CMD     = 1;
  localparam int POS_STAGE   = 16;
  localparam int STAGE_DEPTH = 9;
  localparam int ALARM_W     = 14;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] CMD_UPLOAD    = 8'hD5;
  localparam logic [7:0] CMD_CONNECT   = 8'hE8;
  localparam logic [7:0] CMD_READ      = 8'h3A;
  localparam logic [7:0] MODE_RANGE    = 8'hB7;
  localparam logic [7:0] MODE_AUTO     = 8'hA2;
  localparam logic [7:0] FIO2_AUTO_MAX = 8'd100;
  localparam logic [7:0] FIO2_AUTO_MIN = 8'd21;
  localparam logic [5:0] ALARM_SCALE   = 6'd60;

  // staged frame bytes, counted from the first staged position
  localparam int STG_SPO2_MAX = 0;
  localparam int STG_SPO2_MIN = 1;
  localparam int STG_RESPOND  = 2;
  localparam int STG_PREF     = 3;
  localparam int STG_MODE     = 4;
  localparam int STG_FIO2_MAX = 5;
  localparam int STG_FIO2_MIN = 6;
  localparam int STG_ALARM1   = 7;
  localparam int STG_ALARM2   = 8;

  typedef enum logic [2:0] {
    REPLY_CRC_ERR     = 3'd0,
    REPLY_ACK_UPLOAD  = 3'd1,
    REPLY_ACK_CONNECT = 3'd2,
    REPLY_ACK_READ    = 3'd3,
    REPLY_ACK_UNKNOWN = 3'd4
  } reply_code_t;

  typedef struct packed {
    logic [7:0]         spo2_max;
    logic [7:0]         spo2_min;
    logic [7:0]         spo2_mid;
    logic [7:0]         respond_time;
    logic [7:0]         preferred_fio2;
    logic [7:0]         mode_code;
    logic [7:0]         fio2_max;
    logic [7:0]         fio2_min;
    logic [ALARM_W-1:0] alarm1_seconds;
    logic [ALARM_W-1:0] alarm2_seconds;
  } cmfr_profile_t;

  typedef struct packed {
    logic                        apply;
    logic [STAGE_DEPTH-1:0][7:0] fields;
  } cmfr_upload_t;

  // reflected crc-16, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/crc16_modbus_frame_receiver.sv
// modbus crc-16 frame receiver: byte framing, crc check, reply code and profile store
//
//   channel | dir | handshake          | payload
//   in_     | in  | tvalid / tready    | tdata[7:0]  rx_byte
//   out_    | out | tvalid / tready    | tdata[95:0] reply code and stored profile
//
// one byte per cycle unless a pending result holds a frame's last byte: each byte is
// registered in the input register, and the crc, compare and profile update run in the
// cycle it leaves it, which also registers the frame's result in the result register.
// a pending result stalls only the last byte of the next frame; the bytes before it keep flowing.
// reset clears the byte count, crc, profile and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module crc16_modbus_frame_receiver
  import cmfr_pkg::*;
#(
  parameter int FRAME_BYTES = 27,
  parameter int CRC_SPAN    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] reply_code, [10:3] spo2_max, [18:11] spo2_min, [26:19] spo2_mid,
  // [34:27] respond_time, [42:35] preferred_fio2, [50:43] mode_code,
  // [58:51] fio2_max, [66:59] fio2_min, [80:67] alarm1_seconds,
  // [94:81] alarm2_seconds, [95] zero
  output logic [95:0]      out_tdata
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CRCHI_POS = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] SPAN_POS  = POS_W'(CRC_SPAN);
  localparam logic [POS_W-1:0] CMD_POS   = POS_W'(POS_CMD);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;

  // frame state
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [15:0]                 crc_r, crc_nxt, crc_fed;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [7:0]                  crc_hi_r, crc_hi_nxt;
  logic [STAGE_DEPTH-1:0][7:0] staged_r, staged_nxt;

  // result register
  logic        out_v_r, out_v_nxt;
  reply_code_t reply_r, reply_nxt;

  logic [POS_W-1:0] pos;
  logic             is_last;
  logic             proc;
  logic             crc_ok;
  cmfr_upload_t     upd;
  cmfr_profile_t    prof;

  assign pos     = POS_W'(cnt_r);
  assign is_last = (pos == LAST_POS);
  // only the frame-closing byte needs room in the result register
  assign proc      = in_v_r && (!is_last || !out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;

  always_comb begin
    in_v_nxt   = in_tready ? in_tvalid : in_v_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    cmd_nxt    = cmd_r;
    crc_hi_nxt = crc_hi_r;
    staged_nxt = staged_r;
    out_v_nxt  = out_v_r && !out_tready;
    reply_nxt  = reply_r;
    upd.apply  = 1'b0;

    crc_fed = (pos < SPAN_POS) ? crc_feed(crc_r, in_byte_r) : crc_r;
    crc_ok  = (crc_hi_r == crc_fed[15:8]) && (in_byte_r == crc_fed[7:0]);

    if (proc) begin
      if (pos == CMD_POS) begin
        cmd_nxt = in_byte_r;
      end
      if (pos == CRCHI_POS) begin
        crc_hi_nxt = in_byte_r;
      end
      for (int i = 0; i < STAGE_DEPTH; i++) begin
        if (pos == POS_W'(POS_STAGE + i)) begin
          staged_nxt[i] = in_byte_r;
        end
      end
      if (is_last) begin
        cnt_nxt   = '0;
        crc_nxt   = CRC_INIT;
        out_v_nxt = 1'b1;
        priority if (!crc_ok) begin
          reply_nxt = REPLY_CRC_ERR;
        end else if (cmd_r == CMD_UPLOAD) begin
          reply_nxt = REPLY_ACK_UPLOAD;
          upd.apply = 1'b1;
        end else if (cmd_r == CMD_CONNECT) begin
          reply_nxt = REPLY_ACK_CONNECT;
        end else if (cmd_r == CMD_READ) begin
          reply_nxt = REPLY_ACK_READ;
        end else begin
          reply_nxt = REPLY_ACK_UNKNOWN;
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        crc_nxt = crc_fed;
      end
    end
    // a staged byte may land on the closing position of a short frame
    upd.fields = staged_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
      out_v_r <= 1'b0;
      reply_r <= REPLY_CRC_ERR;
    end else begin
      in_v_r  <= in_v_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      out_v_r <= out_v_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
    cmd_r    <= cmd_nxt;
    crc_hi_r <= crc_hi_nxt;
    staged_r <= staged_nxt;
  end

  cmfr_profile u_profile (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .prof  (prof)
  );

  // the profile only moves on a frame end, so it is steady while a result waits
  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0,
                       prof.alarm2_seconds, prof.alarm1_seconds,
                       prof.fio2_min, prof.fio2_max, prof.mode_code,
                       prof.preferred_fio2, prof.respond_time,
                       prof.spo2_mid, prof.spo2_min, prof.spo2_max,
                       reply_r};

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    POS_W'(cnt_r) <= LAST_POS)
    else $error("byte count beyond frame end");

  a_result_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(proc && is_last))
    else $error("result raised without a closing byte");

  a_profile_only_on_upload: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(prof)) |-> $past(upd.apply && proc && is_last && crc_ok))
    else $error("profile changed outside a good upload frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> ($stable(reply_r) && $stable(prof)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: hdl/cmfr_profile.sv
// stored therapy profile, rewritten from the staged bytes of a good upload frame
`timescale 1ns / 1ps
`default_nettype none

module cmfr_profile
  import cmfr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmfr_upload_t  upd,
  output cmfr_profile_t      prof
);

  cmfr_profile_t prof_r;
  cmfr_profile_t prof_nxt;
  logic [8:0]    spo2_sum;
  logic [7:0]    mode;

  always_comb begin
    mode     = upd.fields[STG_MODE];
    spo2_sum = {1'b0, upd.fields[STG_SPO2_MAX]} + {1'b0, upd.fields[STG_SPO2_MIN]};
    prof_nxt = prof_r;
    if (upd.apply) begin
      prof_nxt.spo2_max       = upd.fields[STG_SPO2_MAX];
      prof_nxt.spo2_min       = upd.fields[STG_SPO2_MIN];
      prof_nxt.spo2_mid       = spo2_sum[8:1];
      prof_nxt.respond_time   = upd.fields[STG_RESPOND];
      prof_nxt.preferred_fio2 = upd.fields[STG_PREF];
      prof_nxt.mode_code      = mode;
      priority if (mode == MODE_RANGE) begin
        prof_nxt.fio2_max = upd.fields[STG_FIO2_MAX];
        prof_nxt.fio2_min = upd.fields[STG_FIO2_MIN];
      end else if (mode == MODE_AUTO) begin
        prof_nxt.fio2_max = FIO2_AUTO_MAX;
        prof_nxt.fio2_min = FIO2_AUTO_MIN;
      end else begin
        // any other mode keeps the old fio2 limits
        prof_nxt.fio2_max = prof_r.fio2_max;
        prof_nxt.fio2_min = prof_r.fio2_min;
      end
      prof_nxt.alarm1_seconds = ALARM_W'(upd.fields[STG_ALARM1]) * ALARM_W'(ALARM_SCALE);
      prof_nxt.alarm2_seconds = ALARM_W'(upd.fields[STG_ALARM2]) * ALARM_W'(ALARM_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_r <= '0;
    end else begin
      prof_r <= prof_nxt;
    end
  end

  assign prof = prof_r;

endmodule

`default_nettype wire

// File: tb/crc16_modbus_frame_receiver_tb.sv
// testbench for the modbus crc-16 frame receiver: frame stimulus, reply prediction and check
`timescale 1ns / 1ps

module crc16_modbus_frame_receiver_tb;
  import cmfr_pkg::*;

  localparam int FRAME_LEN    = 27;
  localparam int CRC_LEN      = 25;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    reply_code_t   code;
    cmfr_profile_t prof;
  } frame_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [2:0] reply_code, [10:3] spo2_max, [18:11] spo2_min, [26:19] spo2_mid,
  // [34:27] respond_time, [42:35] preferred_fio2, [50:43] mode_code,
  // [58:51] fio2_max, [66:59] fio2_min, [80:67] alarm1_seconds,
  // [94:81] alarm2_seconds, [95] zero
  logic [95:0] out_tdata;

  // receive-side mirror of the block
  int            rx_pos = 0;
  logic [15:0]   rx_crc = CRC_INIT;
  logic [7:0]    rx_cmd = 8'h00;
  logic [7:0]    rx_crc_hi = 8'h00;
  logic [7:0]    rx_staged [STAGE_DEPTH];
  cmfr_profile_t stored_profile = '0;
  frame_reply_t  expected_replies [$];

  logic [7:0]    frame_buf [FRAME_LEN];
  int            in_idle_pct = 0;
  int            out_stall_pct = 0;
  int            error_count = 0;
  int            quiet_cycles = 0;

  crc16_modbus_frame_receiver #(
    .FRAME_BYTES (FRAME_LEN),
    .CRC_SPAN    (CRC_LEN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                  input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // advance the mirror by one accepted byte; a frame end queues its reply
  task automatic track_rx_byte(input logic [7:0] b);
    frame_reply_t r;
    logic [8:0]   spo2_sum;
    if (rx_pos < CRC_LEN) rx_crc = modbus_crc_step(rx_crc, b);
    if (rx_pos == POS_CMD) rx_cmd = b;
    if (rx_pos >= POS_STAGE && rx_pos < POS_STAGE + STAGE_DEPTH) begin
      rx_staged[rx_pos - POS_STAGE] = b;
    end
    if (rx_pos == FRAME_LEN - 2) rx_crc_hi = b;
    if (rx_pos < FRAME_LEN - 1) begin
      rx_pos++;
      return;
    end
    if (rx_crc_hi == rx_crc[15:8] && b == rx_crc[7:0]) begin
      case (rx_cmd)
        CMD_UPLOAD: begin
          r.code = REPLY_ACK_UPLOAD;
          spo2_sum = {1'b0, rx_staged[STG_SPO2_MAX]} + {1'b0, rx_staged[STG_SPO2_MIN]};
          stored_profile.spo2_max       = rx_staged[STG_SPO2_MAX];
          stored_profile.spo2_min       = rx_staged[STG_SPO2_MIN];
          stored_profile.spo2_mid       = spo2_sum[8:1];
          stored_profile.respond_time   = rx_staged[STG_RESPOND];
          stored_profile.preferred_fio2 = rx_staged[STG_PREF];
          stored_profile.mode_code      = rx_staged[STG_MODE];
          // any mode other than range or auto leaves the fio2 limits alone
          if (rx_staged[STG_MODE] == MODE_RANGE) begin
            stored_profile.fio2_max = rx_staged[STG_FIO2_MAX];
            stored_profile.fio2_min = rx_staged[STG_FIO2_MIN];
          end else if (rx_staged[STG_MODE] == MODE_AUTO) begin
            stored_profile.fio2_max = FIO2_AUTO_MAX;
            stored_profile.fio2_min = FIO2_AUTO_MIN;
          end
          stored_profile.alarm1_seconds =
            ALARM_W'(rx_staged[STG_ALARM1]) * ALARM_W'(ALARM_SCALE);
          stored_profile.alarm2_seconds =
            ALARM_W'(rx_staged[STG_ALARM2]) * ALARM_W'(ALARM_SCALE);
        end
        CMD_CONNECT: r.code = REPLY_ACK_CONNECT;
        CMD_READ:    r.code = REPLY_ACK_READ;
        default:     r.code = REPLY_ACK_UNKNOWN;
      endcase
    end else begin
      r.code = REPLY_CRC_ERR;
    end
    r.prof = stored_profile;
    expected_replies.push_back(r);
    rx_pos = 0;
    rx_crc = CRC_INIT;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) track_rx_byte(in_tdata);
  end

  always @(posedge clk) begin
    frame_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("reply 0x%0h with no frame pending", out_tdata[2:0]));
      end else begin
        want = expected_replies.pop_front();
        check_field("reply_code", out_tdata[2:0], want.code);
        check_field("spo2_max", out_tdata[10:3], want.prof.spo2_max);
        check_field("spo2_min", out_tdata[18:11], want.prof.spo2_min);
        check_field("spo2_mid", out_tdata[26:19], want.prof.spo2_mid);
        check_field("respond_time", out_tdata[34:27], want.prof.respond_time);
        check_field("preferred_fio2", out_tdata[42:35], want.prof.preferred_fio2);
        check_field("mode_code", out_tdata[50:43], want.prof.mode_code);
        check_field("fio2_max", out_tdata[58:51], want.prof.fio2_max);
        check_field("fio2_min", out_tdata[66:59], want.prof.fio2_min);
        check_field("alarm1_seconds", out_tdata[80:67], want.prof.alarm1_seconds);
        check_field("alarm2_seconds", out_tdata[94:81], want.prof.alarm2_seconds);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // no item moving on either side for too long means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // staged bytes other than the mode byte all equal to fill, or random when fill is negative
  task automatic make_frame(input logic [7:0] cmd, input logic [7:0] mode, input int fill);
    for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'($urandom_range(255));
    if (fill >= 0) begin
      for (int i = 0; i < STAGE_DEPTH; i++) frame_buf[POS_STAGE + i] = fill[7:0];
    end
    frame_buf[POS_CMD] = cmd;
    frame_buf[POS_STAGE + STG_MODE] = mode;
  endtask

  // append the crc; a broken frame then gets one flipped bit somewhere
  task automatic seal_frame(input bit broken);
    logic [15:0] crc;
    int          idx;
    crc = CRC_INIT;
    for (int i = 0; i < CRC_LEN; i++) crc = modbus_crc_step(crc, frame_buf[i]);
    frame_buf[FRAME_LEN - 2] = crc[15:8];
    frame_buf[FRAME_LEN - 1] = crc[7:0];
    if (broken) begin
      idx = $urandom_range(FRAME_LEN - 1);
      frame_buf[idx][$urandom_range(7)] ^= 1'b1;
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_LEN; i++) send_byte(frame_buf[i]);
  endtask

  task automatic test_reply_codes();
    make_frame(CMD_CONNECT, MODE_RANGE, -1); seal_frame(0); send_frame();
    make_frame(CMD_READ, MODE_AUTO, -1);     seal_frame(0); send_frame();
    make_frame(8'h00, MODE_RANGE, 0);        seal_frame(0); send_frame();
    make_frame(8'hFF, MODE_RANGE, 255);      seal_frame(0); send_frame();
    // corrupted upload must not touch the profile
    make_frame(CMD_UPLOAD, MODE_RANGE, -1);  seal_frame(0);
    frame_buf[FRAME_LEN - 1] ^= 8'h01;
    send_frame();
    make_frame(CMD_CONNECT, MODE_AUTO, -1);  seal_frame(0);
    frame_buf[FRAME_LEN - 2] ^= 8'h80;
    send_frame();
  endtask

  task automatic test_upload_modes();
    make_frame(CMD_UPLOAD, MODE_RANGE, 255); seal_frame(0); send_frame();
    make_frame(CMD_UPLOAD, MODE_AUTO, 0);    seal_frame(0); send_frame();
    // unknown mode keeps the auto limits from the frame before
    make_frame(CMD_UPLOAD, 8'h5C, -1);       seal_frame(0); send_frame();
    make_frame(CMD_UPLOAD, MODE_RANGE, -1);  seal_frame(0); send_frame();
    make_frame(CMD_UPLOAD, 8'h00, 255);      seal_frame(0); send_frame();
    make_frame(CMD_UPLOAD, MODE_AUTO, -1);   seal_frame(0); send_frame();
  endtask

  task automatic test_random_traffic(input int n_frames, input int idle_pct,
                                     input int stall_pct);
    int          pick;
    logic [7:0]  cmd;
    logic [7:0]  mode;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int f = 0; f < n_frames; f++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2, 3: mode = MODE_RANGE;
        4, 5, 6:    mode = MODE_AUTO;
        default:    mode = 8'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0:       cmd = CMD_CONNECT;
        1:       cmd = CMD_READ;
        default: cmd = 8'($urandom_range(255));
      endcase
      if (pick < 55) begin
        make_frame(CMD_UPLOAD, mode, -1);
        seal_frame(0);
      end else if (pick < 72) begin
        make_frame(cmd, mode, -1);
        seal_frame(0);
      end else if (pick < 88) begin
        make_frame(($urandom_range(1) != 0) ? CMD_UPLOAD : cmd, mode, -1);
        seal_frame(1);
      end else begin
        for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'($urandom_range(255));
      end
      send_frame();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reply_codes();
    test_upload_modes();
    test_random_traffic(14, 0, 0);
    test_random_traffic(14, 48, 0);
    test_random_traffic(14, 0, 48);
    test_random_traffic(14, 7, 7);
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
